[design/ccq_pkg.sv]
// Shared types and codes for the coalescing command queue.
package ccq_pkg;

   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [2:0] ST_APPENDED = 3'd0;
   localparam logic [2:0] ST_COALESCED = 3'd1;
   localparam logic [2:0] ST_BAD_LEN = 3'd2;
   localparam logic [2:0] ST_FULL = 3'd3;
   localparam logic [2:0] ST_POPPED = 3'd4;
   localparam logic [2:0] ST_EMPTY = 3'd5;
   localparam logic [2:0] ST_CLEARED = 3'd6;

   localparam logic [1:0] CSR_CODE_A = 2'd0;
   localparam logic [1:0] CSR_CODE_B = 2'd1;
   localparam logic [1:0] CSR_CODE_C = 2'd2;

   typedef struct packed {
      logic [63:0] payload;
      logic [15:0] target;
      logic [3:0]  len;
      logic [7:0]  code;
   } ccq_entry_type;

   typedef struct packed {
      logic       load;
      logic       clear;
      logic       pop_read;
      logic       pop_take;
      logic       scan_start;
      logic       scan_run;
      logic       merge;
      logic       append;
      logic       set_status;
      logic [2:0] status;
      logic       emit;
   } ccq_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       bad_len;
      logic       coal;
      logic       empty;
      logic       full;
      logic       hit;
      logic       miss_done;
      logic       rsp_free;
   } ccq_stat_type;

endpackage

[design/coalescing_command_queue_top.sv]
// Top level of the coalescing command queue: stream ports, config port, controller and datapath.
//
// A command queue of QUEUE_DEPTH entries held in one RAM. Push (tuser 0) appends a command,
// or, when its code equals one of the three configured coalescing codes, overwrites the
// payload, length and target of the oldest queued entry with that code in place. Pop (tuser 1)
// returns the oldest entry; clear (tuser 2 or 3) empties the queue. Each request produces
// exactly one response with a status and the fill level after the operation. One request is
// handled at a time. A coalescing push searches the queued entries from the oldest on,
// reading one entry per cycle through the single read port of the entry RAM. The response
// sits in an output register, so a new request is taken while the previous response still
// waits for rsp_tready.
module coalescing_command_queue_top import ccq_pkg::*; #(
   parameter int QUEUE_DEPTH = 8,
   parameter int PAYLOAD_BYTES = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command_code[7:0], payload_len[15:8], target_value[31:16], payload[95:32]
   input  logic [95:0]  req_tdata,
   // opcode[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_command_code[7:0], out_payload_len[11:8], out_target_value[27:12],
   // out_payload[91:28], fill_level[95:92], is_empty[96], is_full[97], zero[103:98]
   output logic [103:0] rsp_tdata,
   // status[2:0]
   output logic [2:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_data
);

   ccq_cmd_type  cmd;
   ccq_stat_type stat;

   logic [7:0]         rsp_code;
   logic [3:0]         rsp_len;
   logic signed [15:0] rsp_target;
   logic [63:0]        rsp_payload;
   logic [3:0]         rsp_fill;
   logic               rsp_empty, rsp_full;

   assign csr_ready = 1'b1;

   ccq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ccq_datapath #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_opcode      (req_tuser),
      .req_command_code(req_tdata[7:0]),
      .req_payload_len (req_tdata[15:8]),
      .req_target_value(req_tdata[31:16]),
      .req_payload     (req_tdata[95:32]),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_tready      (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_status      (rsp_tuser),
      .rsp_command_code(rsp_code),
      .rsp_payload_len (rsp_len),
      .rsp_target_value(rsp_target),
      .rsp_payload     (rsp_payload),
      .rsp_fill_level  (rsp_fill),
      .rsp_is_empty    (rsp_empty),
      .rsp_is_full     (rsp_full)
   );

   assign rsp_tdata = {6'd0, rsp_full, rsp_empty, rsp_fill, rsp_payload, rsp_target,
                       rsp_len, rsp_code};

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while another is in progress");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_EMPTY) |-> (rsp_empty && rsp_fill == 4'd0))
      else $error("empty status with entries queued");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_FULL) |-> rsp_full)
      else $error("full status without a full queue");

   a_append_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ST_APPENDED || rsp_tuser == ST_COALESCED)) |-> !rsp_empty)
      else $error("queue empty after a push was stored");

endmodule

[design/ccq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ccq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/ccq_datapath.sv]
// Datapath: request latch, pointers, fill count, entry RAM, scan and result registers.
module ccq_datapath import ccq_pkg::*; #(
   parameter int QUEUE_DEPTH = 8,
   parameter int PAYLOAD_BYTES = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         req_opcode,
   input  logic [7:0]         req_command_code,
   input  logic [7:0]         req_payload_len,
   input  logic signed [15:0] req_target_value,
   input  logic [63:0]        req_payload,
   input  logic               csr_valid,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_data,
   input  ccq_cmd_type        cmd,
   output ccq_stat_type       stat,
   input  logic               rsp_tready,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic [7:0]         rsp_command_code,
   output logic [3:0]         rsp_payload_len,
   output logic signed [15:0] rsp_target_value,
   output logic [63:0]        rsp_payload,
   output logic [3:0]         rsp_fill_level,
   output logic               rsp_is_empty,
   output logic               rsp_is_full
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   logic [7:0]         code_a_ff, code_b_ff, code_c_ff;
   logic [1:0]         op_ff;
   logic [7:0]         code_ff;
   logic [3:0]         len_ff;
   logic signed [15:0] target_ff;
   logic [63:0]        data_ff;
   logic               bad_len_ff, coal_ff;
   logic [63:0]        data_in;
   logic               bad_len_in;

   logic [PTR_W-1:0] rd_ptr_ff, wr_ptr_ff, scan_addr_ff, cmp_addr_ff;
   logic [CNT_W-1:0] cnt_ff, issued_ff, compared_ff;
   logic             cmp_valid_ff;
   logic             scan_issue;

   logic [2:0]         st_ff;
   logic [7:0]         pop_code_ff;
   logic [3:0]         pop_len_ff;
   logic signed [15:0] pop_target_ff;
   logic [63:0]        pop_payload_ff;

   logic               rsp_valid_ff;
   logic [2:0]         rsp_status_ff;
   logic [7:0]         rsp_code_ff;
   logic [3:0]         rsp_len_ff;
   logic signed [15:0] rsp_target_ff;
   logic [63:0]        rsp_payload_ff;
   logic [3:0]         rsp_fill_ff;
   logic               rsp_empty_ff, rsp_full_ff;

   logic                 ram_we, ram_re;
   logic [PTR_W-1:0]     ram_waddr, ram_raddr;
   ccq_entry_type        ram_wdata, ram_rdata;
   logic [$bits(ccq_entry_type)-1:0] ram_rbits;

   assign bad_len_in = (req_payload_len == 8'd0) ||
                       (req_payload_len > 8'(PAYLOAD_BYTES));

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         data_in[b*8 +: 8] = (8'(b) < req_payload_len) ? req_payload[b*8 +: 8] : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_a_ff <= 8'd17;
         code_b_ff <= 8'd5;
         code_c_ff <= 8'd4;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CODE_A: code_a_ff <= csr_data;
            CSR_CODE_B: code_b_ff <= csr_data;
            CSR_CODE_C: code_c_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_opcode;
         code_ff    <= req_command_code;
         len_ff     <= req_payload_len[3:0];
         target_ff  <= req_target_value;
         data_ff    <= data_in;
         bad_len_ff <= bad_len_in;
         coal_ff    <= (req_command_code == code_a_ff) ||
                       (req_command_code == code_b_ff) ||
                       (req_command_code == code_c_ff);
      end
   end

   assign scan_issue = cmd.scan_run && (issued_ff != cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         cnt_ff       <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            rd_ptr_ff <= '0;
            wr_ptr_ff <= '0;
            cnt_ff    <= '0;
         end
         if (cmd.pop_take) begin
            rd_ptr_ff <= next_slot(rd_ptr_ff);
            cnt_ff    <= cnt_ff - CNT_W'(1);
         end
         if (cmd.append) begin
            wr_ptr_ff <= next_slot(wr_ptr_ff);
            cnt_ff    <= cnt_ff + CNT_W'(1);
         end
         if (cmd.scan_start) begin
            cmp_valid_ff <= 1'b0;
         end else if (cmd.scan_run) begin
            cmp_valid_ff <= scan_issue;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_addr_ff <= rd_ptr_ff;
         issued_ff    <= '0;
         compared_ff  <= '0;
      end else if (cmd.scan_run) begin
         if (scan_issue) begin
            scan_addr_ff <= next_slot(scan_addr_ff);
            cmp_addr_ff  <= scan_addr_ff;
            issued_ff    <= issued_ff + CNT_W'(1);
         end
         if (cmp_valid_ff) begin
            compared_ff <= compared_ff + CNT_W'(1);
         end
      end
   end

   assign ram_re    = cmd.pop_read || scan_issue;
   assign ram_raddr = cmd.pop_read ? rd_ptr_ff : scan_addr_ff;
   assign ram_we    = cmd.merge || cmd.append;
   assign ram_waddr = cmd.merge ? cmp_addr_ff : wr_ptr_ff;

   always_comb begin
      ram_wdata.payload = data_ff;
      ram_wdata.target  = target_ff;
      ram_wdata.len     = len_ff;
      ram_wdata.code    = code_ff;
   end

   ccq_ram #(
      .WIDTH($bits(ccq_entry_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rbits)
   );

   assign ram_rdata = ccq_entry_type'(ram_rbits);

   always_ff @(posedge clock) begin
      if (cmd.set_status) begin
         st_ff <= cmd.status;
      end
      if (cmd.pop_take) begin
         pop_code_ff    <= ram_rdata.code;
         pop_len_ff     <= ram_rdata.len;
         pop_target_ff  <= ram_rdata.target;
         pop_payload_ff <= ram_rdata.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= st_ff;
         if (st_ff == ST_POPPED) begin
            rsp_code_ff    <= pop_code_ff;
            rsp_len_ff     <= pop_len_ff;
            rsp_target_ff  <= pop_target_ff;
            rsp_payload_ff <= pop_payload_ff;
         end else begin
            rsp_code_ff    <= '0;
            rsp_len_ff     <= '0;
            rsp_target_ff  <= '0;
            rsp_payload_ff <= '0;
         end
         rsp_fill_ff  <= 4'(cnt_ff);
         rsp_empty_ff <= (cnt_ff == '0);
         rsp_full_ff  <= (cnt_ff == CNT_W'(QUEUE_DEPTH));
      end
   end

   always_comb begin
      stat.op        = op_ff;
      stat.bad_len   = bad_len_ff;
      stat.coal      = coal_ff;
      stat.empty     = (cnt_ff == '0);
      stat.full      = (cnt_ff == CNT_W'(QUEUE_DEPTH));
      stat.hit       = cmp_valid_ff && (ram_rdata.code == code_ff);
      stat.miss_done = cmp_valid_ff && (ram_rdata.code != code_ff) &&
                       ((compared_ff + CNT_W'(1)) == cnt_ff);
      stat.rsp_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_command_code = rsp_code_ff;
   assign rsp_payload_len  = rsp_len_ff;
   assign rsp_target_value = rsp_target_ff;
   assign rsp_payload      = rsp_payload_ff;
   assign rsp_fill_level   = rsp_fill_ff;
   assign rsp_is_empty     = rsp_empty_ff;
   assign rsp_is_full      = rsp_full_ff;

endmodule

[design/ccq_ctrl.sv]
// Controller state machine: sequences decode, pop, scan, append and result transfer.
module ccq_ctrl import ccq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  ccq_stat_type stat,
   output ccq_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_POP_WAIT = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_APPEND = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.op)
               OP_PUSH: begin
                  if (stat.bad_len) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_BAD_LEN;
                     state_in       = S_DONE;
                  end else if (stat.coal && !stat.empty) begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end else begin
                     state_in = S_APPEND;
                  end
               end
               OP_POP: begin
                  if (stat.empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                     state_in       = S_DONE;
                  end else begin
                     cmd.pop_read = 1'b1;
                     state_in     = S_POP_WAIT;
                  end
               end
               default: begin
                  cmd.clear      = 1'b1;
                  cmd.set_status = 1'b1;
                  cmd.status     = ST_CLEARED;
                  state_in       = S_DONE;
               end
            endcase
         end
         S_POP_WAIT: begin
            cmd.pop_take   = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = ST_POPPED;
            state_in       = S_DONE;
         end
         S_SCAN: begin
            if (stat.hit) begin
               cmd.merge      = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status     = ST_COALESCED;
               state_in       = S_DONE;
            end else if (stat.miss_done) begin
               state_in = S_APPEND;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         S_APPEND: begin
            cmd.set_status = 1'b1;
            if (stat.full) begin
               cmd.status = ST_FULL;
            end else begin
               cmd.append = 1'b1;
               cmd.status = ST_APPENDED;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[tb/tb_coalescing_command_queue_top.sv]
// Self-checking testbench for the coalescing command queue: directed and random traffic.
`timescale 1ns / 1ps

module tb_coalescing_command_queue_top;
   import ccq_pkg::*;

   localparam int QUEUE_DEPTH = 8;
   localparam int PAYLOAD_BYTES = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] OP_UNUSED = OP_CLEAR | OP_POP;

   typedef struct {
      logic [2:0]  status;
      logic [7:0]  code;
      logic [3:0]  len;
      logic [15:0] target;
      logic [63:0] payload;
      logic [3:0]  fill;
      logic        is_empty;
      logic        is_full;
   } queue_response_type;

   typedef enum int {RX_READY, RX_RANDOM, RX_SPARSE, RX_HOLD} rx_mode_type;

   class command_queue_model;
      logic [7:0] coalesce_codes [3];
      ccq_entry_type slots [QUEUE_DEPTH];
      int unsigned head;
      int unsigned tail;
      int unsigned count;
      queue_response_type expected_responses [$];
      int unsigned errors;

      function new();
         coalesce_codes[0] = 8'd17;
         coalesce_codes[1] = 8'd5;
         coalesce_codes[2] = 8'd4;
         head = 0;
         tail = 0;
         count = 0;
         errors = 0;
      endfunction

      function void write_code(logic [1:0] index, logic [7:0] value);
         case (index)
            CSR_CODE_A: coalesce_codes[0] = value;
            CSR_CODE_B: coalesce_codes[1] = value;
            CSR_CODE_C: coalesce_codes[2] = value;
            default: ;
         endcase
      endfunction

      function int unsigned pending_count();
         return expected_responses.size();
      endfunction

      function void accept_command(logic [1:0] op, logic [95:0] data);
         logic [7:0] code;
         logic [7:0] len;
         logic [15:0] target;
         logic [63:0] payload;
         queue_response_type rsp;
         int unsigned p;
         int unsigned i;
         bit merged;
         code = data[7:0];
         len = data[15:8];
         target = data[31:16];
         payload = data[95:32];
         rsp = '{default: '0};
         merged = 1'b0;
         if (op[1]) begin
            head = 0;
            tail = 0;
            count = 0;
            rsp.status = ST_CLEARED;
         end else if (op == OP_POP) begin
            if (count == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               rsp.code = slots[head].code;
               rsp.len = slots[head].len;
               rsp.target = slots[head].target;
               rsp.payload = slots[head].payload;
               head = (head + 1) % QUEUE_DEPTH;
               count--;
               rsp.status = ST_POPPED;
            end
         end else if (len == 0 || len > PAYLOAD_BYTES) begin
            rsp.status = ST_BAD_LEN;
         end else begin
            if (len < 8) payload = payload & ((64'd1 << (8 * len)) - 64'd1);
            if (code == coalesce_codes[0] || code == coalesce_codes[1] ||
                code == coalesce_codes[2]) begin
               p = head;
               for (i = 0; i < count && !merged; i++) begin
                  if (slots[p].code == code) begin
                     slots[p].payload = payload;
                     slots[p].len = len[3:0];
                     slots[p].target = target;
                     merged = 1'b1;
                  end else begin
                     p = (p + 1) % QUEUE_DEPTH;
                  end
               end
            end
            if (merged) begin
               rsp.status = ST_COALESCED;
            end else if (count >= QUEUE_DEPTH) begin
               rsp.status = ST_FULL;
            end else begin
               slots[tail].code = code;
               slots[tail].len = len[3:0];
               slots[tail].target = target;
               slots[tail].payload = payload;
               tail = (tail + 1) % QUEUE_DEPTH;
               count++;
               rsp.status = ST_APPENDED;
            end
         end
         rsp.fill = count[3:0];
         rsp.is_empty = (count == 0);
         rsp.is_full = (count >= QUEUE_DEPTH);
         expected_responses.push_back(rsp);
      endfunction

      function void compare_field(string name, logic [63:0] expv, logic [63:0] actv);
         if (actv !== expv) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
            errors++;
         end
      endfunction

      function void check_response(logic [2:0] status, logic [103:0] data);
         queue_response_type exp_rsp;
         if (expected_responses.size() == 0) begin
            $error("response with status %0d arrived with none outstanding", status);
            errors++;
            return;
         end
         exp_rsp = expected_responses.pop_front();
         compare_field("status", 64'(exp_rsp.status), 64'(status));
         compare_field("out_command_code", 64'(exp_rsp.code), 64'(data[7:0]));
         compare_field("out_payload_len", 64'(exp_rsp.len), 64'(data[11:8]));
         compare_field("out_target_value", 64'(exp_rsp.target), 64'(data[27:12]));
         compare_field("out_payload", exp_rsp.payload, data[91:28]);
         compare_field("fill_level", 64'(exp_rsp.fill), 64'(data[95:92]));
         compare_field("is_empty", 64'(exp_rsp.is_empty), 64'(data[96]));
         compare_field("is_full", 64'(exp_rsp.is_full), 64'(data[97]));
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;
   logic [1:0]   req_tuser = OP_PUSH;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = CSR_CODE_A;
   logic [7:0]   csr_data = '0;

   command_queue_model cmd_model;
   rx_mode_type rx_mode = RX_READY;
   int unsigned rx_timer = 0;
   int unsigned cycle_count = 0;

   coalescing_command_queue_top #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) cmd_model.write_code(csr_index, csr_data);
         if (req_tvalid && req_tready) cmd_model.accept_command(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) cmd_model.check_response(rsp_tuser, rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if (rx_timer == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
         rx_timer <= $urandom_range(10, 60);
      end else begin
         rx_timer <= rx_timer - 1;
      end
      case (rx_mode)
         RX_READY: rsp_tready <= 1'b1;
         RX_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_tready <= (rx_timer[1:0] == 2'd0);
         default: rsp_tready <= (rx_timer[2:0] == 3'd0);
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("coalescing_command_queue_top: mismatch");
         $finish;
      end
   end

   task automatic send_item(logic [1:0] op, logic [7:0] code, logic [7:0] len,
                            logic [15:0] target, logic [63:0] payload);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {payload, target, len, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic push_cmd(logic [7:0] code, logic [7:0] len, logic [15:0] target,
                           logic [63:0] payload);
      send_item(OP_PUSH, code, len, target, payload);
   endtask

   task automatic simple_op(logic [1:0] op);
      send_item(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                16'($urandom_range(0, 16'hffff)), {$urandom, $urandom});
   endtask

   task automatic csr_write(logic [1:0] index, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_codes(logic [7:0] code_a, logic [7:0] code_b, logic [7:0] code_c);
      csr_write(CSR_CODE_A, code_a);
      csr_write(CSR_CODE_B, code_b);
      csr_write(CSR_CODE_C, code_c);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_queue_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (cmd_model.pending_count() != 0);
      @(posedge clock);
   endtask

   task automatic send_random(int unsigned push_pct);
      int unsigned roll;
      logic [7:0] code;
      logic [7:0] len;
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
         case ($urandom_range(0, 3))
            0, 1: code = cmd_model.coalesce_codes[$urandom_range(0, 2)];
            2: code = 8'($urandom_range(0, 3));
            default: code = 8'($urandom_range(0, 255));
         endcase
         if ($urandom_range(0, 99) < 88) len = 8'($urandom_range(1, PAYLOAD_BYTES));
         else if ($urandom_range(0, 1) == 0) len = 8'd0;
         else len = 8'($urandom_range(PAYLOAD_BYTES + 1, 255));
         push_cmd(code, len, 16'($urandom_range(0, 16'hffff)), {$urandom, $urandom});
      end else if (roll < 97) begin
         simple_op(OP_POP);
      end else if (roll < 99) begin
         simple_op(OP_CLEAR);
      end else begin
         simple_op(OP_UNUSED);
      end
   endtask

   task automatic run_random(int unsigned n_items, int unsigned push_pct);
      int unsigned sent;
      int unsigned burst;
      sent = 0;
      while (sent < n_items) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            if (sent < n_items) begin
               send_random(push_pct);
               sent++;
            end
         end
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   initial begin
      cmd_model = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      simple_op(OP_POP);
      push_cmd(8'd17, 8'd0, 16'h0001, '1);
      push_cmd(8'd17, 8'd9, 16'h0002, '1);
      push_cmd(8'd17, 8'd255, 16'h0003, '1);
      push_cmd(8'd17, 8'd1, 16'h8000, '1);
      push_cmd(8'd5, 8'd8, 16'h7fff, '1);
      push_cmd(8'd0, 8'd3, 16'h0000, 64'h0123_4567_89ab_cdef);
      push_cmd(8'd0, 8'd7, 16'hffff, 64'hfedc_ba98_7654_3210);
      push_cmd(8'd17, 8'd8, 16'h1234, 64'haaaa_aaaa_aaaa_aaaa);
      push_cmd(8'd4, 8'd2, 16'h8001, 64'h5555_5555_5555_5555);
      push_cmd(8'd4, 8'd5, 16'h7ffe, 64'h0f0f_0f0f_0f0f_0f0f);
      push_cmd(8'd255, 8'd4, 16'h00ff, 64'hffff_0000_ffff_0000);
      push_cmd(8'd128, 8'd6, 16'hff00, 64'h8000_0000_0000_0001);
      push_cmd(8'd85, 8'd8, 16'h0000, 64'h0);
      push_cmd(8'd170, 8'd4, 16'h4321, '1);
      push_cmd(8'd5, 8'd6, 16'hbeef, 64'hdead_beef_cafe_f00d);
      simple_op(OP_POP);
      simple_op(OP_POP);
      simple_op(OP_CLEAR);
      simple_op(OP_POP);
      push_cmd(8'd5, 8'd4, 16'h0abc, '1);
      simple_op(OP_UNUSED);
      simple_op(OP_POP);

      wait_queue_drained();
      load_codes(8'd0, 8'd255, 8'd128);
      run_random(120, 70);

      wait_queue_drained();
      load_codes(8'd255, 8'd255, 8'd0);
      run_random(60, 50);
      wait_queue_drained();
      run_random(60, 50);

      wait_queue_drained();
      load_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
      run_random(120, 60);

      wait_queue_drained();
      load_codes(8'd17, 8'd5, 8'd4);
      run_random(120, 45);

      wait_queue_drained();
      repeat (20) @(posedge clock);
      if (cmd_model.errors == 0 && cmd_model.pending_count() == 0) begin
         $display("coalescing_command_queue_top: match");
      end else begin
         $display("coalescing_command_queue_top: mismatch");
      end
      $finish;
   end

endmodule

[files.f]
design/ccq_pkg.sv
design/ccq_ram.sv
design/ccq_datapath.sv
design/ccq_ctrl.sv
design/coalescing_command_queue_top.sv
tb/tb_coalescing_command_queue_top.sv
